// File: hdl/assert_macros.svh
// assertion macros used by the checker
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion, switched off while reset is low
`define PBS_ASSERT(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error("pbs assertion failed");

// clocked assertion that also covers reset cycles
`define PBS_ASSERT_RST(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("pbs reset assertion failed");

`endif

// File: hdl/pbs_pkg.sv
// shared types, constants and blend functions of the panorama sampler
// no dependencies
`timescale 1ns / 1ps

package pbs_pkg;

    // field widths
    localparam int OP_W      = 1;
    localparam int LADDR_W   = 21;
    localparam int TEXEL_W   = 24;
    localparam int LON_W     = 28;
    localparam int ROW_W     = 21;
    localparam int VW_W      = 9;
    localparam int HW_W      = 8;
    localparam int CFG_DATA_W  = 28;
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_WIDTH_FIELD_W = 13;

    // longitude plus yaw, and row offset plus column
    localparam int COL_W = LON_W + 1;
    localparam int SUM_W = ROW_W + 1;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    localparam int DEF_SOURCE_DEPTH     = 2097152;
    localparam int DEF_MAX_SOURCE_WIDTH = 4096;
    localparam int WIDTH_RESET          = 2048;
    localparam int MIN_SOURCE_WIDTH     = 2;
    localparam int FULL_WEIGHT          = 256;

    localparam logic [OP_W-1:0] OP_LOAD   = 1'b0;
    localparam logic [OP_W-1:0] OP_RENDER = 1'b1;

    localparam logic [CFG_INDEX_W-1:0] CFG_YAW_OFFSET   = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_SOURCE_WIDTH = 2'd1;

    // one classified item as it waits in the queue
    typedef struct packed {
        logic                render;
        logic                load_ok;
        logic [LADDR_W-1:0]  load_address;
        logic [TEXEL_W-1:0]  load_texel;
        logic [COL_W-1:0]    col_sum;
        logic [ROW_W-1:0]    upper_row;
        logic [ROW_W-1:0]    lower_row;
        logic [VW_W-1:0]     vweight;
    } pbs_item_t;

    // per-stage sideband carried down the back pipeline
    typedef struct packed {
        logic                render;
        logic                load_ok;
        logic [LADDR_W-1:0]  load_address;
        logic [TEXEL_W-1:0]  load_texel;
        logic [HW_W-1:0]     hweight;
        logic [VW_W-1:0]     vweight;
    } pbs_side_t;

    typedef struct packed {
        logic full;
        logic empty;
    } pbs_qstat_t;

    function automatic logic [7:0] blend_chan(input logic [7:0] a, input logic [7:0] b,
                                              input logic [VW_W-1:0] w);
        logic [16:0] acc;
        acc = 17'(a) * 17'(VW_W'(FULL_WEIGHT) - w) + 17'(b) * 17'(w);
        return acc[15:8];
    endfunction

    function automatic logic [TEXEL_W-1:0] blend_texel(input logic [TEXEL_W-1:0] a,
                                                       input logic [TEXEL_W-1:0] b,
                                                       input logic [VW_W-1:0] w);
        return {blend_chan(a[23:16], b[23:16], w),
                blend_chan(a[15:8],  b[15:8],  w),
                blend_chan(a[7:0],   b[7:0],   w)};
    endfunction

endpackage

// File: hdl/pbs_front.sv
// front end: config registers, input accept, yaw add and item classification
// depends on pbs_pkg
`timescale 1ns / 1ps

module pbs_front
    import pbs_pkg::*;
#(
    parameter int SOURCE_DEPTH     = DEF_SOURCE_DEPTH,
    parameter int MAX_SOURCE_WIDTH = DEF_MAX_SOURCE_WIDTH,
    localparam int WIDTH_W = $clog2(MAX_SOURCE_WIDTH + 1)
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   cfg_write_enable,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    input  logic                   s_valid,
    output logic                   s_ready,
    input  logic [OP_W-1:0]        s_op,
    input  logic [LADDR_W-1:0]     s_load_address,
    input  logic [TEXEL_W-1:0]     s_load_texel,
    input  logic [LON_W-1:0]       s_base_longitude,
    input  logic [ROW_W-1:0]       s_upper_row_offset,
    input  logic [ROW_W-1:0]       s_lower_row_offset,
    input  logic [VW_W-1:0]        s_vertical_weight,
    input  pbs_qstat_t             qstat,
    output logic                   push,
    output pbs_item_t              push_item,
    output logic [WIDTH_W-1:0]     source_width
);

    localparam int EW = (WIDTH_W > CFG_WIDTH_FIELD_W) ? WIDTH_W : CFG_WIDTH_FIELD_W;
    localparam int WRST = (WIDTH_RESET > MAX_SOURCE_WIDTH) ? MAX_SOURCE_WIDTH : WIDTH_RESET;

    logic [LON_W-1:0]   yaw_reg;
    logic [WIDTH_W-1:0] width_reg;
    logic [EW-1:0]      width_clamped;
    logic               front_valid_reg;
    pbs_item_t          front_item_reg;
    pbs_item_t          item_next;
    logic               advance;

    always_comb begin
        width_clamped = EW'(cfg_data[CFG_WIDTH_FIELD_W-1:0]);
        if (width_clamped < EW'(MIN_SOURCE_WIDTH)) begin
            width_clamped = EW'(MIN_SOURCE_WIDTH);
        end else if (width_clamped > EW'(MAX_SOURCE_WIDTH)) begin
            width_clamped = EW'(MAX_SOURCE_WIDTH);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            yaw_reg   <= '0;
            width_reg <= WIDTH_W'(WRST);
        end else if (cfg_write_enable) begin
            unique case (cfg_index)
                CFG_YAW_OFFSET:   yaw_reg   <= cfg_data[LON_W-1:0];
                CFG_SOURCE_WIDTH: width_reg <= WIDTH_W'(width_clamped);
                default: ;
            endcase
        end
    end

    always_comb begin
        item_next.render       = (s_op == OP_RENDER);
        item_next.load_ok      = 32'(s_load_address) < 32'(SOURCE_DEPTH);
        item_next.load_address = s_load_address;
        item_next.load_texel   = s_load_texel;
        item_next.col_sum      = COL_W'(s_base_longitude) + COL_W'(yaw_reg);
        item_next.upper_row    = s_upper_row_offset;
        item_next.lower_row    = s_lower_row_offset;
        item_next.vweight      = (s_vertical_weight > VW_W'(FULL_WEIGHT)) ?
                                 VW_W'(FULL_WEIGHT) : s_vertical_weight;
    end

    // front register moves on when empty or when the queue takes it
    assign advance = !front_valid_reg || !qstat.full;
    assign s_ready = advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            front_valid_reg <= 1'b0;
        end else if (advance) begin
            front_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && s_valid) begin
            front_item_reg <= item_next;
        end
    end

    assign push         = front_valid_reg && !qstat.full;
    assign push_item    = front_item_reg;
    assign source_width = width_reg;

endmodule

// File: hdl/pbs_queue.sv
// short fifo between front and back
// depends on pbs_pkg
`timescale 1ns / 1ps

module pbs_queue
    import pbs_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       push,
    input  pbs_item_t  push_item,
    input  logic       pop,
    output pbs_item_t  pop_item,
    output pbs_qstat_t qstat
);

    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    pbs_item_t          entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]  wr_ptr_reg;
    logic [QPTR_W-1:0]  rd_ptr_reg;
    logic [CNT_W-1:0]   count_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + QPTR_W'(1);
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + QPTR_W'(1);
            end
            if (push && !pop) begin
                count_reg <= count_reg + CNT_W'(1);
            end else if (pop && !push) begin
                count_reg <= count_reg - CNT_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_item;
        end
    end

    assign pop_item    = entry_reg[rd_ptr_reg];
    assign qstat.full  = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign qstat.empty = (count_reg == '0);

endmodule

// File: hdl/pbs_addr_mod.sv
// three-stage reduction of a fetch address modulo the source depth
// reciprocal multiply, product back-multiply, one compare and subtract
// depends on pbs_pkg
`timescale 1ns / 1ps

module pbs_addr_mod
    import pbs_pkg::*;
#(
    parameter int SOURCE_DEPTH = DEF_SOURCE_DEPTH,
    localparam int ADDR_W = $clog2(SOURCE_DEPTH)
) (
    input  logic              aclk,
    input  logic              en,
    input  logic [SUM_W-1:0]  sum_in,
    output logic [ADDR_W-1:0] addr_out
);

    localparam int S      = SUM_W + ADDR_W;
    localparam int M_W    = SUM_W + 2;
    localparam int PROD_W = S + SUM_W;
    localparam int QW     = SUM_W + ADDR_W + 1;
    localparam int R_W    = ((SUM_W > ADDR_W) ? SUM_W : ADDR_W) + 1;
    localparam logic [63:0]    RECIP64 = (64'd1 << S) / SOURCE_DEPTH;
    localparam logic [M_W-1:0] RECIP   = M_W'(RECIP64);

    logic [PROD_W-1:0] prod_reg;
    logic [SUM_W-1:0]  sum1_reg;
    logic [SUM_W-1:0]  qd_reg;
    logic [SUM_W-1:0]  sum2_reg;
    logic [ADDR_W-1:0] addr_reg;
    logic [SUM_W-1:0]  quot;
    logic [R_W-1:0]    rem;

    // estimated quotient is exact or one short
    assign quot = prod_reg[S +: SUM_W];

    always_comb begin
        rem = R_W'(sum2_reg - qd_reg);
        if (rem >= R_W'(SOURCE_DEPTH)) begin
            rem = rem - R_W'(SOURCE_DEPTH);
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            prod_reg <= PROD_W'(sum_in) * PROD_W'(RECIP);
            sum1_reg <= sum_in;
            qd_reg   <= SUM_W'(QW'(quot) * QW'(SOURCE_DEPTH));
            sum2_reg <= sum1_reg;
            addr_reg <= ADDR_W'(rem);
        end
    end

    assign addr_out = addr_reg;

endmodule

// File: hdl/pbs_back.sv
// back end: column wrap, fetch addresses, texel store, blends, output register
// depends on pbs_pkg and pbs_addr_mod
`timescale 1ns / 1ps

module pbs_back
    import pbs_pkg::*;
#(
    parameter int SOURCE_DEPTH     = DEF_SOURCE_DEPTH,
    parameter int MAX_SOURCE_WIDTH = DEF_MAX_SOURCE_WIDTH,
    localparam int WIDTH_W = $clog2(MAX_SOURCE_WIDTH + 1)
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic [WIDTH_W-1:0] source_width,
    input  pbs_item_t          pop_item,
    input  pbs_qstat_t         qstat,
    output logic               pop,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [TEXEL_W-1:0] m_pixel_out
);

    localparam int ADDR_W = $clog2(SOURCE_DEPTH);
    localparam int SPAN_W = WIDTH_W + 16;
    localparam int CMP_W  = (COL_W > SPAN_W) ? COL_W : SPAN_W;
    localparam int C0_W   = COL_W - 16;
    localparam int C1_W   = C0_W + 1;
    localparam int EW     = (C1_W > WIDTH_W) ? C1_W : WIDTH_W;
    localparam int NSTAGE = 7;

    logic               en;
    logic [CMP_W-1:0]   col_ext;
    logic [CMP_W-1:0]   span_ext;
    logic [CMP_W-1:0]   col_wrapped;
    logic [C0_W-1:0]    c0;
    logic [C1_W-1:0]    c0_inc;
    logic [C1_W-1:0]    c1;
    pbs_side_t          side_in;

    logic [COL_W-1:0]   col_reg;
    logic [ROW_W-1:0]   upper_reg;
    logic [ROW_W-1:0]   lower_reg;
    logic [SUM_W-1:0]   sum_reg [4];
    logic [ADDR_W-1:0]  fetch_addr [4];
    logic [ADDR_W-1:0]  write_addr;
    logic               write_en;

    pbs_side_t          side_reg [1:NSTAGE];
    logic [NSTAGE:1]    vld_reg;

    logic [TEXEL_W-1:0] mem_up [SOURCE_DEPTH];
    logic [TEXEL_W-1:0] mem_lo [SOURCE_DEPTH];
    logic [TEXEL_W-1:0] up0_reg, up1_reg, lo0_reg, lo1_reg;
    logic [TEXEL_W-1:0] top_reg, bot_reg;
    logic [TEXEL_W-1:0] pixel_reg;
    logic               m_valid_reg;

    // whole back pipeline stalls together on the output register
    assign en  = !m_valid_reg || m_ready;
    assign pop = en && !qstat.empty;

    // one wrap at width times 65536
    always_comb begin
        col_ext     = CMP_W'(pop_item.col_sum);
        span_ext    = CMP_W'({source_width, 16'h0000});
        col_wrapped = (col_ext >= span_ext) ? (col_ext - span_ext) : col_ext;
    end

    always_comb begin
        side_in.render       = pop_item.render;
        side_in.load_ok      = pop_item.load_ok;
        side_in.load_address = pop_item.load_address;
        side_in.load_texel   = pop_item.load_texel;
        side_in.hweight      = col_wrapped[15:8];
        side_in.vweight      = pop_item.vweight;
    end

    // left and right columns, right one wraps to zero
    assign c0     = col_reg[COL_W-1:16];
    assign c0_inc = C1_W'(c0) + C1_W'(1);
    assign c1     = (EW'(c0_inc) == EW'(source_width)) ? '0 : c0_inc;

    always_ff @(posedge aclk) begin
        if (en) begin
            col_reg    <= COL_W'(col_wrapped);
            upper_reg  <= pop_item.upper_row;
            lower_reg  <= pop_item.lower_row;
            sum_reg[0] <= SUM_W'(upper_reg) + SUM_W'(c0);
            sum_reg[1] <= SUM_W'(upper_reg) + SUM_W'(c1);
            sum_reg[2] <= SUM_W'(lower_reg) + SUM_W'(c0);
            sum_reg[3] <= SUM_W'(lower_reg) + SUM_W'(c1);
        end
    end

    for (genvar i = 0; i < 4; i++) begin : g_mod
        pbs_addr_mod #(
            .SOURCE_DEPTH(SOURCE_DEPTH)
        ) u_addr_mod (
            .aclk    (aclk),
            .en      (en),
            .sum_in  (sum_reg[i]),
            .addr_out(fetch_addr[i])
        );
    end

    // sideband delay line, horizontal weight rides along from the pop stage
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[NSTAGE-1:1], pop};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            side_reg[1] <= side_in;
            for (int k = 2; k <= NSTAGE; k++) begin
                side_reg[k] <= side_reg[k-1];
            end
        end
    end

    // loads write both copies at the stage where renders read
    assign write_addr = ADDR_W'(side_reg[5].load_address);
    assign write_en   = en && vld_reg[5] && !side_reg[5].render && side_reg[5].load_ok;

    always_ff @(posedge aclk) begin
        if (write_en) begin
            mem_up[write_addr] <= side_reg[5].load_texel;
        end
        if (en) begin
            up0_reg <= mem_up[fetch_addr[0]];
            up1_reg <= mem_up[fetch_addr[1]];
        end
    end

    always_ff @(posedge aclk) begin
        if (write_en) begin
            mem_lo[write_addr] <= side_reg[5].load_texel;
        end
        if (en) begin
            lo0_reg <= mem_lo[fetch_addr[2]];
            lo1_reg <= mem_lo[fetch_addr[3]];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            top_reg   <= blend_texel(up0_reg, up1_reg, VW_W'(side_reg[6].hweight));
            bot_reg   <= blend_texel(lo0_reg, lo1_reg, VW_W'(side_reg[6].hweight));
            pixel_reg <= blend_texel(top_reg, bot_reg, side_reg[NSTAGE].vweight);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (en) begin
            m_valid_reg <= vld_reg[NSTAGE] && side_reg[NSTAGE].render;
        end
    end

    assign m_valid     = m_valid_reg;
    assign m_pixel_out = pixel_reg;

endmodule

// File: hdl/panorama_bilinear_sampler.sv
// top level of the equirectangular panorama bilinear sampler
// depends on pbs_pkg, pbs_front, pbs_queue, pbs_back
`timescale 1ns / 1ps

// Takes one item per clock while the queue has room, load or render, and
// returns one blended pixel per render item at one per clock while m_ready
// is high; loads give no result. Items leave in order. An item passes the
// front register, the queue, then wrap, column sums, address reduction modulo
// the store depth, the texel read, the row blends and the output register.
// The texel store is kept twice, one copy for the upper row and one for the
// lower, each with one write and two read ports, so all four texels come out
// in the same cycle. A load writes at the same pipeline stage where renders
// read, so a render that follows a load sees it. The back stalls as a whole
// on the output register; the four-entry queue lets the input keep taking
// beats meanwhile until it is full. The store has no reset: texels never
// loaded read as whatever the memory holds. Config writes belong only to
// idle periods.
module panorama_bilinear_sampler
    import pbs_pkg::*;
#(
    parameter int SOURCE_DEPTH     = DEF_SOURCE_DEPTH,
    parameter int MAX_SOURCE_WIDTH = DEF_MAX_SOURCE_WIDTH
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    // config write port
    input  logic                   cfg_write_enable,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    // input beats
    input  logic                   s_valid,
    output logic                   s_ready,
    input  logic [OP_W-1:0]        s_op,
    input  logic [LADDR_W-1:0]     s_load_address,
    input  logic [TEXEL_W-1:0]     s_load_texel,
    input  logic [LON_W-1:0]       s_base_longitude,
    input  logic [ROW_W-1:0]       s_upper_row_offset,
    input  logic [ROW_W-1:0]       s_lower_row_offset,
    input  logic [VW_W-1:0]        s_vertical_weight,
    // result beats
    output logic                   m_valid,
    input  logic                   m_ready,
    output logic [TEXEL_W-1:0]     m_pixel_out
);

    localparam int WIDTH_W = $clog2(MAX_SOURCE_WIDTH + 1);

    // front to queue
    logic               push;
    pbs_item_t          push_item;
    // queue to back
    logic               pop;
    pbs_item_t          pop_item;
    pbs_qstat_t         qstat;
    // configured width, needed by the wrap in the back
    logic [WIDTH_W-1:0] source_width;

    pbs_front #(
        .SOURCE_DEPTH    (SOURCE_DEPTH),
        .MAX_SOURCE_WIDTH(MAX_SOURCE_WIDTH)
    ) u_front (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cfg_write_enable  (cfg_write_enable),
        .cfg_index         (cfg_index),
        .cfg_data          (cfg_data),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_op              (s_op),
        .s_load_address    (s_load_address),
        .s_load_texel      (s_load_texel),
        .s_base_longitude  (s_base_longitude),
        .s_upper_row_offset(s_upper_row_offset),
        .s_lower_row_offset(s_lower_row_offset),
        .s_vertical_weight (s_vertical_weight),
        .qstat             (qstat),
        .push              (push),
        .push_item         (push_item),
        .source_width      (source_width)
    );

    pbs_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .push_item(push_item),
        .pop      (pop),
        .pop_item (pop_item),
        .qstat    (qstat)
    );

    pbs_back #(
        .SOURCE_DEPTH    (SOURCE_DEPTH),
        .MAX_SOURCE_WIDTH(MAX_SOURCE_WIDTH)
    ) u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .source_width(source_width),
        .pop_item    (pop_item),
        .qstat       (qstat),
        .pop         (pop),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_pixel_out (m_pixel_out)
    );

endmodule

// File: hdl/pbs_checker.sv
// port-level checks of the panorama sampler, bound to the top level
// depends on pbs_pkg and assert_macros.svh
`timescale 1ns / 1ps
`include "assert_macros.svh"

module pbs_checker
    import pbs_pkg::*;
(
    input logic               aclk,
    input logic               aresetn,
    input logic               s_ready,
    input logic               m_valid,
    input logic               m_ready,
    input logic [TEXEL_W-1:0] m_pixel_out
);

    // output register and front are empty right after reset
    `PBS_ASSERT_RST(a_no_result_after_reset, aclk, !aresetn |=> !m_valid)
    `PBS_ASSERT_RST(a_ready_after_reset, aclk, !aresetn |=> s_ready)

    // a stalled result beat holds
    `PBS_ASSERT(a_result_holds, aclk, aresetn, m_valid && !m_ready |=> m_valid)
    `PBS_ASSERT(a_pixel_holds, aclk, aresetn, m_valid && !m_ready |=> $stable(m_pixel_out))

endmodule

bind panorama_bilinear_sampler pbs_checker u_pbs_checker (.*);
